FILE: rtl/bfa_pkg.sv
// Shared types and constants for the bitmap frame allocator.
// Field widths of the stream channels, operation codes, controller states
// and the count-update request. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bfa_pkg;

  // Field widths fixed by the channel format
  localparam int OP_W       = 2;
  localparam int START_W    = 16;
  localparam int COUNT_W    = 17;
  localparam int CFG_W      = 17;
  localparam int FRAME_W    = 16;
  localparam int FREE_W     = 17;

  // tdata carries the fields packed from bit 0, padded to whole bytes
  localparam int IN_DATA_W  = ((START_W + COUNT_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((FRAME_W + FREE_W + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_ADD    = 2'd2,
    OP_REMOVE = 2'd3
  } op_t;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_READ  = 6'b000100,
    S_MOD   = 6'b001000,
    S_WRAP  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  // Request to the free-count unit: valid, and count direction
  typedef struct packed {
    logic vld;
    logic up;
  } cnt_req_t;

endpackage

`default_nettype wire

FILE: rtl/bfa_counter.sv
// Free-frame counter with a two-stage popcount pipeline.
// Counts the flagged bits of one bitmap word per request and applies them
// to the saturating count. Depends on bfa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bfa_counter #(
  parameter int NUM_FRAMES = 65536,
  parameter int WORD_BITS  = 32
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire bfa_pkg::cnt_req_t               req,
  input  wire [WORD_BITS-1:0]                  bits,
  output logic                                 busy,
  output logic [$clog2(NUM_FRAMES+1)-1:0]      count
);
  import bfa_pkg::*;

  localparam int FW  = $clog2(NUM_FRAMES + 1);
  localparam int NB  = WORD_BITS / 8;
  localparam int SW  = $clog2(WORD_BITS + 1);

  logic                 a_vld_r, a_up_r;
  logic [WORD_BITS-1:0] a_bits_r;
  logic                 b_vld_r, b_up_r;
  logic [3:0]           b_cnt_r [NB];
  logic [3:0]           byte_cnt [NB];
  logic [SW-1:0]        sum;
  logic [FW:0]          up_sum;
  logic [FW-1:0]        cnt_r, cnt_nxt;

  // Stage A: hold the request word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      a_vld_r <= req.vld;
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    a_up_r   <= req.up;
    a_bits_r <= bits;
    b_up_r   <= a_up_r;
    for (int j = 0; j < NB; j++) begin
      b_cnt_r[j] <= byte_cnt[j];
    end
  end

  // Count ones in each byte
  always_comb begin
    for (int j = 0; j < NB; j++) begin
      byte_cnt[j] = '0;
      for (int k = 0; k < 8; k++) begin
        byte_cnt[j] = byte_cnt[j] + {3'b000, a_bits_r[j*8+k]};
      end
    end
  end

  // Stage B: add byte counts and apply with saturation
  always_comb begin
    sum = '0;
    for (int j = 0; j < NB; j++) begin
      sum = sum + SW'(b_cnt_r[j]);
    end
    up_sum  = {1'b0, cnt_r} + (FW+1)'(sum);
    cnt_nxt = cnt_r;
    if (b_vld_r) begin
      if (b_up_r) begin
        cnt_nxt = (up_sum > (FW+1)'(NUM_FRAMES)) ? FW'(NUM_FRAMES) : up_sum[FW-1:0];
      end else begin
        cnt_nxt = (cnt_r < FW'(sum)) ? '0 : cnt_r - FW'(sum);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign busy  = a_vld_r | b_vld_r;
  assign count = cnt_r;

endmodule

`default_nettype wire

FILE: rtl/bitmap_frame_allocator_core.sv
// Top level of the bitmap page-frame allocator: controller and bitmap memory.
// Depends on bfa_pkg and bfa_counter.
//
//  channel | direction | handshake            | content
//  --------+-----------+----------------------+---------------------------------------
//  cfg     | in        | cfg_valid/cfg_ready  | total_frames
//  in      | in        | in_tvalid/in_tready  | tuser: operation; tdata: start, count
//  out     | out       | out_tvalid/out_tready| tuser: success; tdata: frame, free count
//
// After reset the bitmap is swept to all-used, one word a cycle over MAP_WORDS words
// (2048 at the default sizes), during which no transaction is accepted.
// One transaction at a time. The bitmap memory port visits one word a cycle, so
// an item's time grows with each bitmap word scanned or spanned
// (allocate: words from the cursor to the total, then from the reserved base).
// A waiting result holds in the output register; the next item is still taken.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_frame_allocator_core #(
  parameter int NUM_FRAMES      = 65536,
  parameter int WORD_BITS       = 32,   // power of two
  parameter int RESERVED_FRAMES = 256
) (
  input  wire                              clk,
  input  wire                              rst_n,
  // configuration write
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire [bfa_pkg::CFG_W-1:0]         cfg_data,     // total_frames
  // requests
  input  wire                              in_tvalid,
  output logic                             in_tready,
  input  wire [bfa_pkg::IN_DATA_W-1:0]     in_tdata,     // start_frame, frame_count
  input  wire [bfa_pkg::OP_W-1:0]          in_tuser,     // operation
  // results
  output logic                             out_tvalid,
  input  wire                              out_tready,
  output logic [bfa_pkg::OUT_DATA_W-1:0]   out_tdata,    // frame, free_frames
  output logic [0:0]                       out_tuser     // success
);
  import bfa_pkg::*;

  localparam int FW        = $clog2(NUM_FRAMES + 1);
  localparam int XW        = (FW > 18) ? FW : 18;
  localparam int WSH       = $clog2(WORD_BITS);
  localparam int MAP_WORDS = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = $clog2(MAP_WORDS);

  // Bitmap memory
  logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
  logic [WORD_BITS-1:0] rd_data_r;
  logic                 rd_en, wr_en;
  logic [AW-1:0]        rd_addr, wr_addr;
  logic [WORD_BITS-1:0] wr_data;

  // Control and payload registers
  state_t          state_r, state_nxt;
  op_t             op_r, op_nxt, op_in;
  logic            wrap_r, wrap_nxt;
  logic [FW-1:0]   lo_r, lo_nxt, hi_r, hi_nxt;
  logic [AW-1:0]   waddr_r, waddr_nxt, clr_r, clr_nxt;
  logic [FW-1:0]   cur_r, cur_nxt;
  logic [CFG_W-1:0] total_r;
  logic [FW-1:0]   frame_r, frame_nxt;
  logic            ok_r, ok_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [FRAME_W-1:0] out_frame_r, out_frame_nxt;
  logic [FREE_W-1:0]  out_free_r, out_free_nxt;
  logic            out_ok_r, out_ok_nxt;

  // Count unit
  cnt_req_t             req;
  logic [WORD_BITS-1:0] req_bits;
  logic                 cnt_busy;
  logic [FW-1:0]        cnt_val;

  // Range arithmetic
  logic [XW-1:0] start_x, end_x, tot_x, cur_x, res_x, num_x;
  logic [XW-1:0] acc_lo, acc_hi, wrap_lo, wrap_hi;
  logic [XW-1:0] base_x, lo_x, hi_x, hi_d;
  logic [WSH-1:0] lo_off, hi_off, pick_idx;
  logic           hi_full, last_w, hit;
  logic [WORD_BITS-1:0] mask, free_bits, used_bits, cand, pick_oh;

  assign op_in   = op_t'(in_tuser);
  assign start_x = XW'(in_tdata[START_W-1:0]);
  assign end_x   = start_x + XW'(in_tdata[START_W +: COUNT_W]);
  assign num_x   = XW'(NUM_FRAMES);
  assign res_x   = XW'(RESERVED_FRAMES);
  assign cur_x   = XW'(cur_r);
  assign tot_x   = (XW'(total_r) > num_x) ? num_x : XW'(total_r);

  // Frame range of each operation, [lo, hi)
  always_comb begin
    case (op_in)
      OP_ALLOC: begin
        acc_lo = cur_x;
        acc_hi = tot_x;
      end
      OP_FREE: begin
        acc_lo = start_x;
        acc_hi = (start_x + XW'(1) < tot_x) ? start_x + XW'(1) : tot_x;
      end
      OP_ADD: begin
        acc_lo = (start_x > res_x) ? start_x : res_x;
        acc_hi = (end_x < tot_x) ? end_x : tot_x;
      end
      default: begin
        acc_lo = start_x;
        acc_hi = (end_x < num_x) ? end_x : num_x;
      end
    endcase
    wrap_lo = res_x;
    wrap_hi = (cur_x < tot_x) ? cur_x : tot_x;
  end

  // Mask of the current word's bits inside the range
  always_comb begin
    base_x  = XW'({waddr_r, {WSH{1'b0}}});
    lo_x    = XW'(lo_r);
    hi_x    = XW'(hi_r);
    lo_off  = (lo_x > base_x) ? WSH'(lo_x - base_x) : '0;
    hi_d    = hi_x - base_x;
    hi_full = (hi_d >= XW'(WORD_BITS));
    hi_off  = WSH'(hi_d);
    mask    = ({WORD_BITS{1'b1}} << lo_off) &
              (hi_full ? {WORD_BITS{1'b1}} : ~({WORD_BITS{1'b1}} << hi_off));
    last_w  = (waddr_r == AW'((hi_x - XW'(1)) >> WSH));
    free_bits = ~rd_data_r & mask;
    used_bits = rd_data_r & mask;
    cand      = (op_r == OP_FREE) ? used_bits : free_bits;
  end

  // Find the lowest candidate bit
  always_comb begin
    pick_idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (cand[i]) pick_idx = WSH'(i);
    end
    hit     = |cand;
    pick_oh = {{(WORD_BITS-1){1'b0}}, 1'b1} << pick_idx;
  end

  // Controller
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    wrap_nxt      = wrap_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    waddr_nxt     = waddr_r;
    clr_nxt       = clr_r;
    cur_nxt       = cur_r;
    frame_nxt     = frame_r;
    ok_nxt        = ok_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_frame_nxt = out_frame_r;
    out_free_nxt  = out_free_r;
    out_ok_nxt    = out_ok_r;
    rd_en         = 1'b0;
    rd_addr       = waddr_r;
    wr_en         = 1'b0;
    wr_addr       = waddr_r;
    wr_data       = rd_data_r;
    req           = '0;
    req_bits      = mask;

    case (state_r)
      S_CLEAR: begin
        // sweep the bitmap to all-used
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = {WORD_BITS{1'b1}};
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(MAP_WORDS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt    = op_in;
          wrap_nxt  = 1'b0;
          frame_nxt = '0;
          ok_nxt    = 1'b0;
          lo_nxt    = FW'(acc_lo);
          hi_nxt    = FW'(acc_hi);
          waddr_nxt = AW'(acc_lo >> WSH);
          if (acc_lo < acc_hi) begin
            state_nxt = S_READ;
          end else if (op_in == OP_ALLOC) begin
            state_nxt = S_WRAP;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_WRAP: begin
        // second allocate pass from the reserved base up to the cursor
        wrap_nxt  = 1'b1;
        lo_nxt    = FW'(wrap_lo);
        hi_nxt    = FW'(wrap_hi);
        waddr_nxt = AW'(wrap_lo >> WSH);
        state_nxt = (wrap_lo < wrap_hi) ? S_READ : S_DONE;
      end
      S_READ: begin
        rd_en     = 1'b1;
        rd_addr   = waddr_r;
        state_nxt = S_MOD;
      end
      S_MOD: begin
        case (op_r)
          OP_ALLOC: begin
            if (hit) begin
              wr_en     = 1'b1;
              wr_data   = rd_data_r | pick_oh;
              frame_nxt = FW'(base_x + XW'(pick_idx));
              cur_nxt   = FW'(base_x + XW'(pick_idx) + XW'(1));
              ok_nxt    = 1'b1;
              req.vld   = 1'b1;
              req.up    = 1'b0;
              req_bits  = pick_oh;
              state_nxt = S_DONE;
            end else if (last_w) begin
              state_nxt = wrap_r ? S_DONE : S_WRAP;
            end else begin
              waddr_nxt = waddr_r + AW'(1);
              rd_en     = 1'b1;
              rd_addr   = waddr_r + AW'(1);
            end
          end
          OP_FREE: begin
            if (hit) begin
              wr_en   = 1'b1;
              wr_data = rd_data_r & ~mask;
              ok_nxt  = 1'b1;
              req.vld = 1'b1;
              req.up  = 1'b1;
            end
            state_nxt = S_DONE;
          end
          OP_ADD: begin
            // every frame in range counts as newly free
            wr_en   = 1'b1;
            wr_data = rd_data_r & ~mask;
            req.vld = 1'b1;
            req.up  = 1'b1;
            if (last_w) begin
              state_nxt = S_DONE;
            end else begin
              waddr_nxt = waddr_r + AW'(1);
              rd_en     = 1'b1;
              rd_addr   = waddr_r + AW'(1);
            end
          end
          default: begin
            // remove: only frames that were free take the count down
            wr_en    = 1'b1;
            wr_data  = rd_data_r | mask;
            req.vld  = 1'b1;
            req.up   = 1'b0;
            req_bits = free_bits;
            if (last_w) begin
              state_nxt = S_DONE;
            end else begin
              waddr_nxt = waddr_r + AW'(1);
              rd_en     = 1'b1;
              rd_addr   = waddr_r + AW'(1);
            end
          end
        endcase
      end
      S_DONE: begin
        // wait for the count to settle and the output register to free up
        if (!cnt_busy && (!out_valid_r || out_tready)) begin
          out_valid_nxt = 1'b1;
          out_frame_nxt = FRAME_W'(frame_r);
          out_free_nxt  = FREE_W'(cnt_val);
          out_ok_nxt    = ok_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Bitmap memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) map_mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= map_mem[rd_addr];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      cur_r       <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cur_r       <= cur_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) total_r <= cfg_data;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    wrap_r      <= wrap_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    waddr_r     <= waddr_nxt;
    frame_r     <= frame_nxt;
    ok_r        <= ok_nxt;
    out_frame_r <= out_frame_nxt;
    out_free_r  <= out_free_nxt;
    out_ok_r    <= out_ok_nxt;
  end

  bfa_counter #(
    .NUM_FRAMES (NUM_FRAMES),
    .WORD_BITS  (WORD_BITS)
  ) u_counter (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .bits  (req_bits),
    .busy  (cnt_busy),
    .count (cnt_val)
  );

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'({out_free_r, out_frame_r});
  assign out_tuser  = out_ok_r;

endmodule

`default_nettype wire

FILE: rtl/bfa_checker.sv
// Port-level checks for the bitmap frame allocator, bound to the top level.
// Depends on bfa_pkg and bitmap_frame_allocator_core.
`timescale 1ns / 1ps
`default_nettype none

module bfa_checker #(
  parameter int NUM_FRAMES = 65536
) (
  input wire                            clk,
  input wire                            rst_n,
  input wire                            in_tvalid,
  input wire                            in_tready,
  input wire                            out_tvalid,
  input wire                            out_tready,
  input wire [bfa_pkg::OUT_DATA_W-1:0]  out_tdata,
  input wire [0:0]                      out_tuser
);
  import bfa_pkg::*;

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // One item in flight: no second transaction right after one is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while another is in progress");

  // A failed result carries frame zero
  a_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[FRAME_W-1:0] == '0)
    else $error("nonzero frame without success");

  // The reported free count never exceeds the frame total
  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[FRAME_W +: FREE_W] <= NUM_FRAMES)
    else $error("free count above frame total");

endmodule

bind bitmap_frame_allocator_core bfa_checker #(
  .NUM_FRAMES (NUM_FRAMES)
) u_bfa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

FILE: bench/tb_bitmap_frame_allocator_core.sv
`timescale 1ns / 1ps
// Self-checking bench for bitmap_frame_allocator_core: a directed table, then
// random phases under several frame totals, every result scored in order.
// Depends on bfa_pkg and the allocator RTL; reads no files.
module tb_bitmap_frame_allocator_core;
  import bfa_pkg::*;

  localparam int MAP_FRAMES   = 65536;
  localparam int LOW_FRAMES   = 256;
  localparam int STALL_LIMIT  = 20000;
  localparam int HOLD_CYCLES  = 500;
  localparam int DRAIN_CYCLES = 64;
  localparam int PHASES       = 9;

  typedef struct {
    logic [FRAME_W-1:0] frame;
    logic               ok;
    logic [FREE_W-1:0]  free_frames;
  } alloc_reply_t;

  typedef struct {
    bit           typed;
    alloc_reply_t reply;
  } reply_note_t;

  typedef struct {
    bit           cfg_row;
    int unsigned  cfg_val;
    op_t          op;
    int unsigned  start;
    int unsigned  cnt;
    bit           typed;
    alloc_reply_t reply;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_W-1:0]      cfg_data = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [OP_W-1:0]       in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [0:0]            out_tuser;

  // Predicted allocator state
  bit          frame_used [MAP_FRAMES];
  int unsigned free_tally  = 0;
  int unsigned scan_cursor = 0;
  int unsigned pred_total  = 0;

  alloc_reply_t reply_q [$];
  reply_note_t  note_q [$];
  int unsigned  live_frames [$];
  plan_row_t    plan [$];

  int unsigned gen_total    = 0;
  bit          quiet        = 1'b0;
  int unsigned hold_asks    = 0;
  int unsigned holds_served = 0;
  int unsigned hold_left    = 0;
  int unsigned fail_count   = 0;

  bitmap_frame_allocator_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Clock: 12 ns period
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Apply one transaction to the predicted bitmap and report the result
  task automatic predict_request(input op_t op, input int unsigned start,
                                 input int unsigned cnt, output alloc_reply_t rep);
    int unsigned lim, stop, cur, wrap_hi, f, got;
    bit found;
    lim = (pred_total > MAP_FRAMES) ? MAP_FRAMES : pred_total;
    stop = start + cnt;
    found = 1'b0;
    got = 0;
    rep.frame = '0;
    rep.ok = 1'b0;
    case (op)
      OP_ALLOC: begin
        // next fit: cursor up to the total, then wrap from the reserved base
        cur = scan_cursor;
        wrap_hi = (cur < lim) ? cur : lim;
        f = cur;
        while (!found && f < lim) begin
          if (!frame_used[f]) begin
            found = 1'b1;
            got = f;
          end
          f++;
        end
        f = LOW_FRAMES;
        while (!found && f < wrap_hi) begin
          if (!frame_used[f]) begin
            found = 1'b1;
            got = f;
          end
          f++;
        end
        if (found) begin
          frame_used[got] = 1'b1;
          if (free_tally > 0) free_tally--;
          scan_cursor = got + 1;
          rep.frame = got[FRAME_W-1:0];
          rep.ok = 1'b1;
        end
      end
      OP_FREE: begin
        if (start < lim && frame_used[start]) begin
          frame_used[start] = 1'b0;
          if (free_tally < MAP_FRAMES) free_tally++;
          rep.ok = 1'b1;
        end
      end
      OP_ADD: begin
        // counts every frame in range, already free or not
        f = (start < LOW_FRAMES) ? LOW_FRAMES : start;
        while (f < stop && f < lim) begin
          frame_used[f] = 1'b0;
          if (free_tally < MAP_FRAMES) free_tally++;
          f++;
        end
      end
      default: begin
        if (stop > MAP_FRAMES) stop = MAP_FRAMES;
        for (f = start; f < stop; f++) begin
          if (!frame_used[f] && free_tally > 0) free_tally--;
          frame_used[f] = 1'b1;
        end
      end
    endcase
    rep.free_frames = free_tally[FREE_W-1:0];
  endtask

  // Score accepted transactions on every channel
  always @(posedge clk) begin
    alloc_reply_t want, got;
    reply_note_t  note;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) pred_total = cfg_data;
      if (in_tvalid && in_tready) begin
        predict_request(op_t'(in_tuser), in_tdata[START_W-1:0],
                        in_tdata[START_W +: COUNT_W], want);
        if (want.ok && op_t'(in_tuser) == OP_ALLOC) begin
          live_frames.push_back(want.frame);
          if (live_frames.size() > 512) void'(live_frames.pop_front());
        end
        note = note_q.pop_front();
        if (note.typed) want = note.reply;
        reply_q.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        got.frame = out_tdata[FRAME_W-1:0];
        got.ok = out_tuser[0];
        got.free_frames = out_tdata[FRAME_W +: FREE_W];
        if (reply_q.size() == 0) begin
          $error("result with no request pending: frame %0d", got.frame);
          fail_count++;
        end else begin
          want = reply_q.pop_front();
          if (got.frame !== want.frame) begin
            $error("frame: expected %0d, got %0d", want.frame, got.frame);
            fail_count++;
          end
          if (got.ok !== want.ok) begin
            $error("success: expected %0d, got %0d", want.ok, got.ok);
            fail_count++;
          end
          if (got.free_frames !== want.free_frames) begin
            $error("free_frames: expected %0d, got %0d", want.free_frames,
                   got.free_frames);
            fail_count++;
          end
        end
      end
    end
  end

  // Result backpressure: random stalls, quiet stretch, one long hold-off
  always @(negedge clk) begin
    if (hold_asks != holds_served) begin
      holds_served = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (quiet) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= 18);
    end
  end

  // Watchdog: end the run when no channel moves for too long
  initial begin
    int unsigned stalled;
    stalled = 0;
    while (stalled < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready))
        stalled = 0;
      else
        stalled++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic plan_row_t step_row(op_t op, int unsigned start, int unsigned cnt,
                                         bit typed, int unsigned efrm, bit eok,
                                         int unsigned efree);
    plan_row_t r;
    r.cfg_row = 1'b0;
    r.cfg_val = 0;
    r.op = op;
    r.start = start;
    r.cnt = cnt;
    r.typed = typed;
    r.reply.frame = efrm[FRAME_W-1:0];
    r.reply.ok = eok;
    r.reply.free_frames = efree[FREE_W-1:0];
    return r;
  endfunction

  function automatic plan_row_t cfg_row(int unsigned val);
    plan_row_t r;
    r = step_row(OP_ALLOC, 0, 0, 1'b0, 0, 1'b0, 0);
    r.cfg_row = 1'b1;
    r.cfg_val = val;
    return r;
  endfunction

  // Offer one request; hold valid until the request is taken
  task automatic offer_request(input op_t op, input logic [START_W-1:0] start,
                               input logic [COUNT_W-1:0] cnt, input bit typed,
                               input alloc_reply_t reply);
    reply_note_t note;
    note.typed = typed;
    note.reply = reply;
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 18) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    note_q.push_back(note);
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= IN_DATA_W'({cnt, start});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Write total_frames once every pending result is back
  task automatic write_total(input int unsigned val);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (reply_q.size() != 0) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= val[CFG_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    gen_total = val;
  endtask

  // Mostly allocate/free traffic on live frames, small regions, rare large ones
  task automatic random_request(output op_t op, output logic [START_W-1:0] st,
                                output logic [COUNT_W-1:0] ct);
    int unsigned pick, size_pick, reach, idx;
    pick = $urandom_range(99);
    size_pick = $urandom_range(99);
    reach = (gen_total + 64 > 65535) ? 65535 : gen_total + 64;
    if ($urandom_range(4) == 0) st = START_W'($urandom);
    else st = START_W'($urandom_range(reach));
    if (size_pick < 90) ct = COUNT_W'($urandom_range(64));
    else if (size_pick < 97) ct = COUNT_W'($urandom_range(gen_total));
    else ct = COUNT_W'($urandom_range(MAP_FRAMES));
    if (pick < 40) begin
      op = OP_ALLOC;
      ct = COUNT_W'($urandom_range(MAP_FRAMES));
    end else if (pick < 70) begin
      op = OP_FREE;
      ct = COUNT_W'($urandom_range(MAP_FRAMES));
      if (live_frames.size() != 0 && $urandom_range(3) != 0) begin
        idx = $urandom_range(live_frames.size() - 1);
        st = START_W'(live_frames[idx]);
        live_frames.delete(idx);
      end
    end else if (pick < 85) begin
      op = OP_ADD;
    end else begin
      op = OP_REMOVE;
    end
  endtask

  initial begin
    alloc_reply_t blank;
    op_t op;
    logic [START_W-1:0] st;
    logic [COUNT_W-1:0] ct;
    int unsigned phase_total [PHASES];
    int unsigned phase_items [PHASES];

    phase_total = '{1024, 512, 2048, 300, 65536, 0, 4096, 777, 1024};
    phase_items = '{110, 110, 110, 100, 30, 30, 110, 110, 110};
    blank = '{default: '0};
    foreach (frame_used[i]) frame_used[i] = 1'b1;

    // Total is 0 after reset: nothing can be freed, added or handed out
    plan.push_back(step_row(OP_ALLOC, 0, 0, 1'b1, 0, 1'b0, 0));
    plan.push_back(step_row(OP_FREE, 5, 0, 1'b1, 0, 1'b0, 0));
    plan.push_back(step_row(OP_ADD, 256, 100, 1'b1, 0, 1'b0, 0));
    plan.push_back(cfg_row(1024));
    // second add over the same range counts the frames again
    plan.push_back(step_row(OP_ADD, 0, 1024, 1'b1, 0, 1'b0, 768));
    plan.push_back(step_row(OP_ADD, 0, 1024, 1'b1, 0, 1'b0, 1536));
    // a low frame freed below the reserved base is handed out ahead of the cursor; frame 0, behind it, is not
    plan.push_back(step_row(OP_FREE, 3, 0, 1'b1, 0, 1'b1, 1537));
    plan.push_back(step_row(OP_ALLOC, 0, 65536, 1'b1, 3, 1'b1, 1536));
    plan.push_back(step_row(OP_FREE, 0, 0, 1'b1, 0, 1'b1, 1537));
    plan.push_back(step_row(OP_ALLOC, 65535, 0, 1'b1, 256, 1'b1, 1536));
    // free of a frame already free, at the total, and far out of range
    plan.push_back(step_row(OP_FREE, 300, 0, 1'b1, 0, 1'b0, 1536));
    plan.push_back(step_row(OP_FREE, 1024, 0, 1'b1, 0, 1'b0, 1536));
    plan.push_back(step_row(OP_FREE, 65535, 65536, 1'b1, 0, 1'b0, 1536));
    // empty region, and a region clamped at the top of the bitmap
    plan.push_back(step_row(OP_REMOVE, 0, 0, 1'b1, 0, 1'b0, 1536));
    plan.push_back(step_row(OP_REMOVE, 65535, 65536, 1'b1, 0, 1'b0, 1536));
    plan.push_back(step_row(OP_REMOVE, 256, 768, 1'b0, 0, 1'b0, 0));
    plan.push_back(step_row(OP_ALLOC, 0, 0, 1'b0, 0, 1'b0, 0));
    plan.push_back(cfg_row(65536));
    plan.push_back(step_row(OP_ADD, 65280, 65536, 1'b0, 0, 1'b0, 0));
    plan.push_back(step_row(OP_ALLOC, 0, 0, 1'b0, 0, 1'b0, 0));
    plan.push_back(step_row(OP_ALLOC, 0, 0, 1'b0, 0, 1'b0, 0));
    // shrink the total under the cursor: wrap scan stops at the total
    plan.push_back(cfg_row(300));
    plan.push_back(step_row(OP_ALLOC, 0, 0, 1'b0, 0, 1'b0, 0));
    plan.push_back(step_row(OP_ADD, 0, 65536, 1'b0, 0, 1'b0, 0));
    plan.push_back(step_row(OP_ALLOC, 0, 0, 1'b0, 0, 1'b0, 0));
    // full-range adds drive the count into saturation, then take it all back
    plan.push_back(cfg_row(65536));
    plan.push_back(step_row(OP_ADD, 0, 65536, 1'b0, 0, 1'b0, 0));
    plan.push_back(step_row(OP_ADD, 0, 65536, 1'b0, 0, 1'b0, 0));
    plan.push_back(step_row(OP_REMOVE, 0, 65536, 1'b0, 0, 1'b0, 0));

    // Hold reset, then release it
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[k]) begin
      if (plan[k].cfg_row)
        write_total(plan[k].cfg_val);
      else
        offer_request(plan[k].op, plan[k].start[START_W-1:0], plan[k].cnt[COUNT_W-1:0],
                      plan[k].typed, plan[k].reply);
    end

    // Random phases, each seeded with a full-range add
    for (int p = 0; p < PHASES; p++) begin
      write_total(phase_total[p]);
      quiet = (p == 2);
      offer_request(OP_ADD, '0, phase_total[p][COUNT_W-1:0], 1'b0, blank);
      for (int i = 0; i < phase_items[p]; i++) begin
        if (p == PHASES - 1 && i == 40) hold_asks++;
        random_request(op, st, ct);
        offer_request(op, st, ct, 1'b0, blank);
      end
      quiet = 1'b0;
    end

    // Drain, then let the block settle
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (reply_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: sim.f
rtl/bfa_pkg.sv
rtl/bfa_counter.sv
rtl/bitmap_frame_allocator_core.sv
rtl/bfa_checker.sv
bench/tb_bitmap_frame_allocator_core.sv
